@@ hw/rtl/smh_pkg.sv @@
// Shared types, constants and helper functions for the SHA-1 message hasher.
`default_nettype none

package smh_pkg;

	localparam int unsigned Rounds      = 80;
	localparam int unsigned BlockWords  = 16;
	localparam int unsigned DigestWords = 5;
	localparam int unsigned LenPos      = 56;
	localparam int unsigned LenSlot     = LenPos / 4;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] InitHash [DigestWords] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  bytes_valid;
		logic        end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_HADD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_CHOOSE,
		PH_PARITY_A,
		PH_MAJORITY,
		PH_PARITY_B
	} phase_t;

	typedef struct packed {
		logic load;
		logic step;
	} sched_ctl_t;

	typedef struct packed {
		logic       step;
		logic       first;
		phase_t     phase;
		logic       hadd;
		logic       init;
		logic [2:0] sel;
	} core_ctl_t;

	function automatic phase_t round_phase(input logic [6:0] r);
		phase_t p;
		if (r inside {[7'd0:7'd19]}) begin
			p = PH_CHOOSE;
		end else if (r inside {[7'd20:7'd39]}) begin
			p = PH_PARITY_A;
		end else if (r inside {[7'd40:7'd59]}) begin
			p = PH_MAJORITY;
		end else begin
			p = PH_PARITY_B;
		end
		return p;
	endfunction

	function automatic logic [31:0] round_const(input phase_t p);
		logic [31:0] k;
		case (p)
			PH_CHOOSE:   k = 32'h5A827999;
			PH_PARITY_A: k = 32'h6ED9EBA1;
			PH_MAJORITY: k = 32'h8F1BBCDC;
			PH_PARITY_B: k = 32'hCA62C1D6;
			default:     k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/smh_sched.sv @@
// Sixteen-word message schedule window, filled by shifting and advanced once per round.
`default_nettype none

module smh_sched (
	input  wire                 clk,
	input  smh_pkg::sched_ctl_t ctl,
	input  wire [31:0]          word,
	output logic [31:0]         w_cur
);
	import smh_pkg::*;

	logic [31:0] w_q [BlockWords];
	logic [31:0] mix;
	logic [31:0] fb;

	always_comb begin
		mix   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		fb    = {mix[30:0], mix[31]};
		w_cur = w_q[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.step) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BlockWords - 1] <= ctl.load ? word : fb;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/smh_core.sv @@
// Shared SHA-1 round unit with working variables and chaining registers.
`default_nettype none

module smh_core (
	input  wire                clk,
	input  wire                arst_n,
	input  smh_pkg::core_ctl_t ctl,
	input  wire [31:0]         w_cur,
	output logic [31:0]        digest_word
);
	import smh_pkg::*;

	logic [31:0] hash_q [DigestWords];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] a_i, b_i, c_i, d_i, e_i;
	logic [31:0] f;
	logic [31:0] t;

	always_comb begin
		if (ctl.first) begin
			a_i = hash_q[0];
			b_i = hash_q[1];
			c_i = hash_q[2];
			d_i = hash_q[3];
			e_i = hash_q[4];
		end else begin
			a_i = a_q;
			b_i = b_q;
			c_i = c_q;
			d_i = d_q;
			e_i = e_q;
		end
		case (ctl.phase)
			PH_CHOOSE:   f = ((c_i ^ d_i) & b_i) ^ d_i;
			PH_MAJORITY: f = (b_i & c_i) | (b_i & d_i) | (c_i & d_i);
			default:     f = b_i ^ c_i ^ d_i;
		endcase
		t = {a_i[26:0], a_i[31:27]} + f + e_i + round_const(ctl.phase) + w_cur;
		case (ctl.sel)
			3'd0:    digest_word = hash_q[0];
			3'd1:    digest_word = hash_q[1];
			3'd2:    digest_word = hash_q[2];
			3'd3:    digest_word = hash_q[3];
			3'd4:    digest_word = hash_q[4];
			default: digest_word = hash_q[4];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			a_q <= t;
			b_q <= a_i;
			c_q <= {b_i[1:0], b_i[31:2]};
			d_q <= c_i;
			e_q <= d_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DigestWords; i++) begin
				hash_q[i] <= InitHash[i];
			end
		end else if (ctl.init) begin
			for (int i = 0; i < DigestWords; i++) begin
				hash_q[i] <= InitHash[i];
			end
		end else if (ctl.hadd) begin
			hash_q[0] <= hash_q[0] + a_q;
			hash_q[1] <= hash_q[1] + b_q;
			hash_q[2] <= hash_q[2] + c_q;
			hash_q[3] <= hash_q[3] + d_q;
			hash_q[4] <= hash_q[4] + e_q;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/smh_ctrl.sv @@
// Sequencer for block filling, padding, rounds and digest output.
`default_nettype none

module smh_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 msg_valid,
	output logic                msg_ready,
	input  smh_pkg::msg_item_t  msg_data,
	output logic                digest_valid,
	input  wire                 digest_ready,
	output smh_pkg::sched_ctl_t sched_ctl,
	output logic [31:0]         sched_word,
	output smh_pkg::core_ctl_t  core_ctl,
	output logic [2:0]          word_index,
	output logic                last_word
);
	import smh_pkg::*;

	state_t      state_q, state_d;
	logic [3:0]  slot_q;
	logic [6:0]  rnd_q;
	logic [63:0] bc_q;
	logic        fin_q, pend_q, len_q, done_q;
	logic [2:0]  idx_q;

	logic        msg_acc, dig_acc, dig_end;
	logic [2:0]  nbytes;
	logic [31:0] fin_word;
	logic [31:0] pad_word;
	logic [63:0] bits;
	logic        slot_full;

	always_comb begin
		msg_acc   = msg_valid && msg_ready;
		dig_acc   = digest_valid && digest_ready;
		dig_end   = dig_acc && (idx_q == 3'(DigestWords - 1));
		nbytes    = (msg_data.bytes_valid > 3'd4) ? 3'd4 : msg_data.bytes_valid;
		bits      = {bc_q[60:0], 3'b000};
		slot_full = (slot_q == 4'(BlockWords - 1));
		case (nbytes)
			3'd0:    fin_word = {PadByte, 24'h0};
			3'd1:    fin_word = {msg_data.data_word[31:24], PadByte, 16'h0};
			3'd2:    fin_word = {msg_data.data_word[31:16], PadByte, 8'h0};
			3'd3:    fin_word = {msg_data.data_word[31:8], PadByte};
			default: fin_word = msg_data.data_word;
		endcase
		if (pend_q) begin
			pad_word = {PadByte, 24'h0};
		end else if (slot_q == 4'(LenSlot)) begin
			pad_word = bits[63:32];
		end else if (slot_full && len_q) begin
			pad_word = bits[31:0];
		end else begin
			pad_word = 32'h0;
		end
	end

	always_comb begin
		state_d        = state_q;
		msg_ready      = 1'b0;
		digest_valid   = 1'b0;
		sched_ctl      = '0;
		sched_word     = msg_data.data_word;
		core_ctl       = '0;
		core_ctl.phase = round_phase(rnd_q);
		core_ctl.first = (rnd_q == 7'd0);
		core_ctl.sel   = idx_q;
		word_index     = idx_q;
		last_word      = (idx_q == 3'(DigestWords - 1));
		case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_acc) begin
					sched_ctl.load = 1'b1;
					sched_word     = msg_data.end_of_message ? fin_word : msg_data.data_word;
					if (slot_full) begin
						state_d = ST_ROUND;
					end else if (msg_data.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				sched_ctl.load = 1'b1;
				sched_word     = pad_word;
				if (slot_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				sched_ctl.step = 1'b1;
				core_ctl.step  = 1'b1;
				if (rnd_q == 7'(Rounds - 1)) begin
					state_d = ST_HADD;
				end
			end
			ST_HADD: begin
				core_ctl.hadd = 1'b1;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (done_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				digest_valid = 1'b1;
				if (dig_end) begin
					core_ctl.init = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			rnd_q  <= '0;
			bc_q   <= '0;
			fin_q  <= 1'b0;
			pend_q <= 1'b0;
			len_q  <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (sched_ctl.load) begin
				slot_q <= slot_q + 4'd1;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= (rnd_q == 7'(Rounds - 1)) ? 7'd0 : rnd_q + 7'd1;
			end
			if (msg_acc) begin
				if (msg_data.end_of_message) begin
					bc_q   <= bc_q + {61'd0, nbytes};
					fin_q  <= 1'b1;
					pend_q <= (nbytes == 3'd4);
				end else begin
					bc_q <= bc_q + 64'd4;
				end
			end
			if (state_q == ST_PAD) begin
				pend_q <= 1'b0;
				if (!pend_q && slot_q == 4'(LenSlot)) begin
					len_q <= 1'b1;
				end
				if (!pend_q && slot_full && len_q) begin
					done_q <= 1'b1;
				end
			end
			if (dig_acc) begin
				idx_q <= dig_end ? 3'd0 : idx_q + 3'd1;
			end
			if (dig_end) begin
				bc_q   <= '0;
				fin_q  <= 1'b0;
				len_q  <= 1'b0;
				done_q <= 1'b0;
			end
		end
	end

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= 7'(Rounds - 1))
		else $error("Round counter left its range.");

	a_hadd_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HADD |-> $past(state_q) == ST_ROUND && $past(rnd_q) == 7'(Rounds - 1))
		else $error("Chaining add without a completed set of rounds.");

	a_out_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> slot_q == 4'd0 && done_q && fin_q)
		else $error("Digest offered before the padded message was consumed.");

	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		dig_end |=> state_q == ST_IDLE && bc_q == 64'd0 && idx_q == 3'd0 && !fin_q)
		else $error("State not reinitialised after the final digest transfer.");

endmodule

`default_nettype wire

@@ hw/rtl/sha1_message_hasher.sv @@
// Top level of the SHA-1 message hasher.
// Message words are taken one per cycle while a 16-word block fills; the sixteenth transfer
// starts the single shared round unit, which runs the 80 rounds at one per cycle and then adds
// the result into the chaining registers. On the final word the padding and the bit length
// are shifted into the schedule one word per cycle, which may take a second block of rounds,
// and then the five digest words are offered as five transfers, word 0 first. The block is
// not ready for input while it compresses, pads or offers the digest.
`default_nettype none

module sha1_message_hasher (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   msg_valid,
	output logic                  msg_ready,
	input  smh_pkg::msg_item_t    msg_data,
	output logic                  digest_valid,
	input  wire                   digest_ready,
	output smh_pkg::digest_item_t digest_data
);
	import smh_pkg::*;

	sched_ctl_t  sched_ctl;
	core_ctl_t   core_ctl;
	logic [31:0] sched_word;
	logic [31:0] w_cur;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	smh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.msg_data     (msg_data),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.sched_ctl    (sched_ctl),
		.sched_word   (sched_word),
		.core_ctl     (core_ctl),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	smh_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.word  (sched_word),
		.w_cur (w_cur)
	);

	smh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (core_ctl),
		.w_cur       (w_cur),
		.digest_word (digest_word)
	);

	always_comb begin
		digest_data.digest_word = digest_word;
		digest_data.word_index  = word_index;
		digest_data.last_word   = last_word;
	end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the SHA-1 message hasher, with randomised message traffic.
`default_nettype none

module tb_top;
	import smh_pkg::*;

	localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
	localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
	localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         msg_valid = 1'b0;
	logic         msg_ready;
	msg_item_t    msg_data = '0;
	logic         digest_valid;
	logic         digest_ready = 1'b0;
	digest_item_t digest_data;

	msg_item_t    word_queue[$];
	digest_item_t digest_due[$];

	logic [31:0] sha_chain [DigestWords];
	logic [31:0] sha_block [BlockWords];
	logic [63:0] sha_bytes = '0;

	logic msg_fire = 1'b0;
	int   send_gap = 0;
	int   send_calm = 0;
	int   stall_left = 0;
	int   stall_calm = 0;
	int   mismatches = 0;

	sha1_message_hasher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg_data(msg_data),
		.digest_valid(digest_valid),
		.digest_ready(digest_ready),
		.digest_data(digest_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic sha_compress();
		logic [31:0] w [BlockWords];
		logic [31:0] a, b, c, d, e, f, k, t;
		w = sha_block;
		a = sha_chain[0];
		b = sha_chain[1];
		c = sha_chain[2];
		d = sha_chain[3];
		e = sha_chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
					^ w[r % 16], 1);
			end
			if (r < 20) begin
				f = ((c ^ d) & b) ^ d;
				k = K_CHOOSE;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PARITY_A;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJORITY;
			end else begin
				f = b ^ c ^ d;
				k = K_PARITY_B;
			end
			t = rotl(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		sha_chain[0] += a;
		sha_chain[1] += b;
		sha_chain[2] += c;
		sha_chain[3] += d;
		sha_chain[4] += e;
	endtask

	task automatic sha_put_byte(inout int pos, input logic [7:0] value);
		sha_block[pos / 4][8 * (3 - pos % 4) +: 8] = value;
		if (pos == 63) begin
			sha_compress();
		end
		pos = (pos + 1) % 64;
	endtask

	task automatic sha_absorb(input msg_item_t item);
		int pos;
		int taken;
		logic [63:0] bit_len;
		pos = int'(sha_bytes[5:0]);
		if (!item.end_of_message) begin
			for (int i = 0; i < 4; i++) begin
				sha_put_byte(pos, item.data_word[8 * (3 - i) +: 8]);
			end
			sha_bytes += 64'd4;
		end else begin
			taken = (item.bytes_valid > 3'd4) ? 4 : int'(item.bytes_valid);
			for (int i = 0; i < taken; i++) begin
				sha_put_byte(pos, item.data_word[8 * (3 - i) +: 8]);
			end
			sha_bytes += 64'(taken);
			bit_len = sha_bytes << 3;
			sha_put_byte(pos, PadByte);
			while (pos != LenPos) begin
				sha_put_byte(pos, 8'h00);
			end
			for (int i = 0; i < 8; i++) begin
				sha_put_byte(pos, bit_len[8 * (7 - i) +: 8]);
			end
			for (int j = 0; j < DigestWords; j++) begin
				digest_due.push_back('{digest_word: sha_chain[j], word_index: 3'(j),
					last_word: (j == DigestWords - 1)});
			end
			sha_chain = InitHash;
			sha_bytes = '0;
		end
	endtask

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
		end
		if (r < 55) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] pick_data();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 32'h00000000;
		end
		if (r == 1) begin
			return 32'hFFFFFFFF;
		end
		return $urandom;
	endfunction

	task automatic queue_message(input int full_words, input logic [2:0] tail_valid);
		logic [2:0] bv;
		for (int i = 0; i < full_words; i++) begin
			bv = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
			word_queue.push_back('{data_word: pick_data(), bytes_valid: bv,
				end_of_message: 1'b0});
		end
		word_queue.push_back('{data_word: pick_data(), bytes_valid: tail_valid,
			end_of_message: 1'b1});
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!msg_valid || msg_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					msg_valid <= 1'b0;
				end else if (word_queue.size() != 0) begin
					msg_data <= word_queue.pop_front();
					msg_valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					msg_valid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				digest_ready <= 1'b0;
			end else begin
				digest_ready <= 1'b1;
				stall_left = pick_gap(stall_calm);
			end
		end
	end

	always @(posedge clk) begin
		digest_item_t due;
		msg_fire <= msg_valid && msg_ready;
		if (arst_n && msg_valid && msg_ready) begin
			sha_absorb(msg_data);
		end
		if (arst_n && digest_valid && digest_ready) begin
			if (digest_due.size() == 0) begin
				$display("%0t: unexpected digest transfer, expected none, got %p",
					$time, digest_data);
				mismatches++;
			end else begin
				due = digest_due.pop_front();
				if (digest_data.digest_word !== due.digest_word) begin
					$display("%0t: digest_word expected %h, got %h",
						$time, due.digest_word, digest_data.digest_word);
					mismatches++;
				end
				if (digest_data.word_index !== due.word_index) begin
					$display("%0t: word_index expected %0d, got %0d",
						$time, due.word_index, digest_data.word_index);
					mismatches++;
				end
				if (digest_data.last_word !== due.last_word) begin
					$display("%0t: last_word expected %b, got %b",
						$time, due.last_word, digest_data.last_word);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int len;
		sha_chain = InitHash;
		sha_block = '{default: '0};

		// Empty message, then single-word messages with every tail length.
		word_queue.push_back('{data_word: 32'hFFFFFFFF, bytes_valid: 3'd0,
			end_of_message: 1'b1});
		for (int v = 1; v < 8; v++) begin
			word_queue.push_back('{data_word: (v % 2) ? 32'hFFFFFFFF : 32'h00000000,
				bytes_valid: 3'(v), end_of_message: 1'b1});
		end
		// Fifty-five bytes: the longest message whose padding fits in one block.
		queue_message(13, 3'd3);

		while (word_queue.size() < 200) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(17, 40);
			end else begin
				len = $urandom_range(0, 16);
			end
			queue_message(len, ($urandom_range(0, 4) == 0) ?
				3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4)));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() != 0 || msg_valid || digest_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (digest_due.size() != 0) begin
			$display("%0t: %0d digest words expected, got none",
				$time, digest_due.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

@@ sha1_message_hasher.f @@
hw/rtl/smh_pkg.sv
hw/rtl/smh_sched.sv
hw/rtl/smh_core.sv
hw/rtl/smh_ctrl.sv
hw/rtl/sha1_message_hasher.sv
verif/tb_top.sv
